@@ rtl/core/cisu_pkg.sv @@
// Shared constants and types for the circular FIFO with search.
package cisu_pkg;

  localparam int CISU_DEPTH      = 256;
  localparam int CISU_DATA_WIDTH = 32;
  localparam int CAP_W           = 9;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  localparam logic [2:0] MODE_ENQ  = 3'd0;
  localparam logic [2:0] MODE_DEQ  = 3'd1;
  localparam logic [2:0] MODE_PEEK = 3'd2;
  localparam logic [2:0] MODE_CLR  = 3'd3;
  localparam logic [2:0] MODE_SRCH = 3'd4;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_NOTFOUND = 2'd3
  } cisu_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_SRD,
    ST_SCMP,
    ST_DONE
  } cisu_state_t;

  typedef struct packed {
    logic we;
    logic re;
  } cisu_mem_ctl_t;

endpackage

@@ rtl/core/cisu_ram.sv @@
// Single-port slot memory with registered read data.
module cisu_ram import cisu_pkg::*; #(
  parameter int DEPTH      = CISU_DEPTH,
  parameter int DATA_WIDTH = CISU_DATA_WIDTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  cisu_mem_ctl_t         mem_ctl,
  input  logic [AW-1:0]         addr,
  input  logic [DATA_WIDTH-1:0] wdata,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (mem_ctl.we) begin
      mem[addr] <= wdata;
    end
    if (mem_ctl.re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ rtl/core/cisu_ctrl.sv @@
// Sequencer, pointers and shared compare unit of the circular FIFO.
module cisu_ctrl import cisu_pkg::*; #(
  parameter int DEPTH      = CISU_DEPTH,
  parameter int DATA_WIDTH = CISU_DATA_WIDTH,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   in_mode,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  input  logic                         cfg_we,
  input  logic [CAP_W-1:0]             cfg_wdata,
  output cisu_mem_ctl_t                mem_ctl,
  output logic [AW-1:0]                mem_addr,
  output logic [DATA_WIDTH-1:0]        mem_wdata,
  input  logic [DATA_WIDTH-1:0]        mem_rdata,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic signed [DATA_WIDTH-1:0] out_data_out,
  output logic [AW-1:0]                out_found_slot,
  output logic [CW-1:0]                out_occupancy,
  output logic                         out_is_empty,
  output logic                         out_is_full
);

  cisu_state_t           state_r, state_nxt;
  logic [2:0]            op_r, op_nxt;
  logic [DATA_WIDTH-1:0] key_r, key_nxt;
  logic [CAP_W-1:0]      cap_r, cap_nxt;
  logic [AW-1:0]         head_r, head_nxt;
  logic [AW-1:0]         tail_r, tail_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [CW-1:0]         scan_r, scan_nxt;
  cisu_status_t          status_r, status_nxt;
  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic [AW-1:0]         slot_r, slot_nxt;

  logic [CW-1:0] cap_use;
  logic          full;
  logic          empty;
  logic          match;
  logic          last;

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx,
                                            input logic [CW-1:0] cap);
    logic [CW-1:0] n;
    n = CW'(idx) + 1'b1;
    return (n >= cap) ? '0 : AW'(n);
  endfunction

  always_comb begin
    if (cap_r == '0) begin
      cap_use = CW'(1);
    end else if (32'(cap_r) > 32'(DEPTH)) begin
      cap_use = CW'(DEPTH);
    end else begin
      cap_use = CW'(cap_r);
    end
  end

  assign full  = (count_r >= cap_use);
  assign empty = (count_r == '0);
  assign match = (mem_rdata == key_r);
  assign last  = ((scan_r + 1'b1) == count_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        case (op_r)
          MODE_DEQ, MODE_PEEK: state_nxt = empty ? ST_DONE : ST_RDWAIT;
          MODE_SRCH:           state_nxt = empty ? ST_DONE : ST_SCMP;
          default:             state_nxt = ST_DONE;
        endcase
      end
      ST_RDWAIT: state_nxt = ST_DONE;
      ST_SRD:    state_nxt = ST_SCMP;
      ST_SCMP: begin
        state_nxt = (match || last) ? ST_DONE : ST_SRD;
      end
      ST_DONE:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_ctl   = '0;
    mem_addr  = head_r;
    mem_wdata = key_r;
    unique case (state_r)
      ST_EXEC: begin
        case (op_r)
          MODE_ENQ: begin
            mem_ctl.we = !full;
            mem_addr   = tail_r;
          end
          MODE_DEQ, MODE_PEEK, MODE_SRCH: mem_ctl.re = !empty;
          default: ;
        endcase
      end
      ST_SRD: begin
        mem_ctl.re = 1'b1;
        mem_addr   = idx_r;
      end
      default: ;
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);

  always_comb begin
    op_nxt     = op_r;
    key_nxt    = key_r;
    cap_nxt    = cap_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    scan_nxt   = scan_r;
    status_nxt = status_r;
    data_nxt   = data_r;
    slot_nxt   = slot_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt  = in_mode;
          key_nxt = in_value;
        end
      end
      ST_EXEC: begin
        status_nxt = STAT_OK;
        data_nxt   = '0;
        slot_nxt   = '0;
        case (op_r)
          MODE_ENQ: begin
            if (full) begin
              status_nxt = STAT_FULL;
            end else begin
              tail_nxt  = advance(tail_r, cap_use);
              count_nxt = count_r + 1'b1;
            end
          end
          MODE_DEQ, MODE_PEEK: begin
            if (empty) status_nxt = STAT_EMPTY;
          end
          MODE_CLR: begin
            head_nxt  = '0;
            tail_nxt  = '0;
            count_nxt = '0;
          end
          MODE_SRCH: begin
            idx_nxt  = head_r;
            scan_nxt = '0;
            if (empty) status_nxt = STAT_NOTFOUND;
          end
          default: ;
        endcase
      end
      ST_RDWAIT: begin
        data_nxt = mem_rdata;
        if (op_r == MODE_DEQ) begin
          head_nxt  = advance(head_r, cap_use);
          count_nxt = count_r - 1'b1;
        end
      end
      ST_SCMP: begin
        if (match) begin
          slot_nxt = idx_r;
        end else if (last) begin
          status_nxt = STAT_NOTFOUND;
        end else begin
          idx_nxt  = advance(idx_r, cap_use);
          scan_nxt = scan_r + 1'b1;
        end
      end
      default: ;
    endcase
    if (cfg_we) begin
      cap_nxt   = cfg_wdata;
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cap_r   <= CAP_RESET;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      cap_r   <= cap_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    idx_r    <= idx_nxt;
    scan_r   <= scan_nxt;
    status_r <= status_nxt;
    data_r   <= data_nxt;
    slot_r   <= slot_nxt;
  end

  assign out_status     = status_r;
  assign out_data_out   = data_r;
  assign out_found_slot = slot_r;
  assign out_occupancy  = count_r;
  assign out_is_empty   = empty;
  assign out_is_full    = full;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cap_use)
    else $error("occupancy above capacity");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CW'(head_r) < cap_use) && (CW'(tail_r) < cap_use))
    else $error("pointer outside capacity");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == ST_EXEC))
    else $error("transfer not taken");

  a_cmp_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCMP) |-> $past(mem_ctl.re))
    else $error("compare without read");

  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RDWAIT && op_r == MODE_DEQ && !cfg_we)
      |=> (count_r == $past(count_r) - 1'b1))
    else $error("dequeue count not decremented");

endmodule

@@ rtl/core/circular_int_fifo_with_search_unit.sv @@
// Result strobe in DONE: enqueue/clear/other reach it from EXEC, dequeue/peek through RDWAIT.
// Search: EXEC, then SCMP, and SRD plus SCMP per further slot until a match or the last entry.
// Empty dequeue/peek/search skip to DONE. Busy stays high until the strobe cycle ends;
// no request is taken while busy. The single read port of the slot memory feeds one comparator.
// Synchronous active-low reset empties the queue and sets capacity to 256; slots stay unset.
// The receiver cannot stall: each result is valid for exactly one cycle.
module circular_int_fifo_with_search_unit import cisu_pkg::*; #(
  parameter int DEPTH      = CISU_DEPTH,
  parameter int DATA_WIDTH = CISU_DATA_WIDTH,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   in_mode,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  input  logic                         cfg_we,
  input  logic [CAP_W-1:0]             cfg_wdata,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic signed [DATA_WIDTH-1:0] out_data_out,
  output logic [AW-1:0]                out_found_slot,
  output logic [CW-1:0]                out_occupancy,
  output logic                         out_is_empty,
  output logic                         out_is_full
);

  cisu_mem_ctl_t         mem_ctl;
  logic [AW-1:0]         mem_addr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [DATA_WIDTH-1:0] mem_rdata;

  cisu_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_value       (in_value),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mem_ctl        (mem_ctl),
    .mem_addr       (mem_addr),
    .mem_wdata      (mem_wdata),
    .mem_rdata      (mem_rdata),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_data_out   (out_data_out),
    .out_found_slot (out_found_slot),
    .out_occupancy  (out_occupancy),
    .out_is_empty   (out_is_empty),
    .out_is_full    (out_is_full)
  );

  cisu_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .addr    (mem_addr),
    .wdata   (mem_wdata),
    .rdata   (mem_rdata)
  );

endmodule

@@ verif/circular_int_fifo_with_search_unit_tb.sv @@
// Testbench for circular_int_fifo_with_search_unit: random and directed requests vs. a predictor.
module circular_int_fifo_with_search_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cisu_pkg::*;

  localparam int SLOTS = CISU_DEPTH;
  localparam int DW = CISU_DATA_WIDTH;
  localparam logic [2:0] MODE_UNUSED_MAX = 3'd7;
  localparam logic signed [DW-1:0] WORD_MAX = 32'sh7fffffff;
  localparam logic signed [DW-1:0] WORD_MIN = 32'sh80000000;

  typedef struct {
    logic [2:0]           mode;
    logic signed [DW-1:0] word;
  } fifo_req_t;

  typedef struct {
    cisu_status_t         status;
    logic signed [DW-1:0] data;
    logic [7:0]           slot;
    logic [8:0]           occ;
    logic                 empty;
    logic                 full;
  } fifo_rsp_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_mode = MODE_ENQ;
  logic signed [DW-1:0] in_value = '0;
  logic cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic signed [DW-1:0] out_data_out;
  logic [7:0] out_found_slot;
  logic [8:0] out_occupancy;
  logic out_is_empty;
  logic out_is_full;

  circular_int_fifo_with_search_unit uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_value      (in_value),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_data_out  (out_data_out),
    .out_found_slot(out_found_slot),
    .out_occupancy (out_occupancy),
    .out_is_empty  (out_is_empty),
    .out_is_full   (out_is_full)
  );

  fifo_req_t req_q[$];
  fifo_rsp_t rsp_q[$];
  int unsigned idle_pct = 0;
  int unsigned xfers = 0;
  int unsigned xfers_seen = 0;
  int errors = 0;
  logic signed [DW-1:0] key_pool[8];

  // predictor state
  logic signed [DW-1:0] q_mem[SLOTS];
  int unsigned q_head, q_tail, q_count;
  logic [CAP_W-1:0] q_cap_reg;

  function automatic int unsigned cap_used();
    if (q_cap_reg == 0) return 1;
    if (q_cap_reg > SLOTS) return SLOTS;
    return 32'(q_cap_reg);
  endfunction

  function automatic int unsigned next_slot(int unsigned idx, int unsigned cap);
    return (idx + 1 >= cap) ? 0 : idx + 1;
  endfunction

  function automatic fifo_rsp_t fifo_apply(logic [2:0] mode, logic signed [DW-1:0] word);
    fifo_rsp_t r;
    int unsigned cap;
    int unsigned idx;
    int unsigned i;
    cap = cap_used();
    r.status = STAT_OK;
    r.data = '0;
    r.slot = '0;
    case (mode)
      MODE_ENQ: begin
        if (q_count >= cap) begin
          r.status = STAT_FULL;
        end else begin
          q_mem[q_tail] = word;
          q_tail = next_slot(q_tail, cap);
          q_count++;
        end
      end
      MODE_DEQ, MODE_PEEK: begin
        if (q_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.data = q_mem[q_head];
          if (mode == MODE_DEQ) begin
            q_head = next_slot(q_head, cap);
            q_count--;
          end
        end
      end
      MODE_CLR: begin
        q_head = 0;
        q_tail = 0;
        q_count = 0;
      end
      MODE_SRCH: begin
        r.status = STAT_NOTFOUND;
        idx = q_head;
        for (i = 0; i < q_count; i++) begin
          if (q_mem[idx] == word) begin
            r.status = STAT_OK;
            r.slot = idx[7:0];
            break;
          end
          idx = next_slot(idx, cap);
        end
      end
      default: begin
      end
    endcase
    r.occ = q_count[8:0];
    r.empty = (q_count == 0);
    r.full = (q_count >= cap);
    return r;
  endfunction

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      errors++;
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // monitor and predictor
  always @(posedge clk) begin
    fifo_rsp_t want;
    if (!rst_n) begin
      q_head = 0;
      q_tail = 0;
      q_count = 0;
      q_cap_reg = CAP_RESET;
    end else begin
      if (cfg_we) begin
        q_cap_reg = cfg_wdata;
        q_head = 0;
        q_tail = 0;
        q_count = 0;
      end
      if (out_valid) begin
        if (rsp_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %h data %h",
                   $time, out_status, out_data_out);
          errors++;
        end else begin
          want = rsp_q.pop_front();
          check_field("status", want.status, out_status);
          check_field("data_out", want.data, out_data_out);
          check_field("found_slot", want.slot, out_found_slot);
          check_field("occupancy", want.occ, out_occupancy);
          check_field("is_empty", want.empty, out_is_empty);
          check_field("is_full", want.full, out_is_full);
        end
      end
      if (start && !busy) begin
        rsp_q.push_back(fifo_apply(in_mode, in_value));
        void'(req_q.pop_front());
        xfers++;
      end
    end
  end

  // driver: holds a request until its transfer, then maybe idles
  always @(negedge clk) begin
    logic taken;
    taken = (xfers != xfers_seen);
    xfers_seen = xfers;
    if (!start || taken) begin
      if (req_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        in_mode <= req_q[0].mode;
        in_value <= req_q[0].word;
      end else begin
        start <= 1'b0;
        in_mode <= 3'($urandom);
        in_value <= $urandom;
      end
    end
  end

  task automatic add_req(logic [2:0] mode, logic signed [DW-1:0] word);
    fifo_req_t t;
    t.mode = mode;
    t.word = word;
    req_q.push_back(t);
  endtask

  task automatic wait_drained();
    while (req_q.size() != 0 || rsp_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_wdata <= CAP_W'($urandom);
  endtask

  function automatic logic signed [DW-1:0] pick_word();
    if ($urandom_range(99) < 60) return key_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  task automatic run_phase(logic [CAP_W-1:0] cap, int unsigned idle, int n,
                           int unsigned enq_pct, bit allow_clr);
    int unsigned r;
    logic [2:0] mode;
    set_capacity(cap);
    idle_pct = idle;
    for (int k = 4; k < 8; k++) key_pool[k] = $urandom;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < enq_pct) begin
        mode = MODE_ENQ;
      end else begin
        r = $urandom_range(99);
        if (r < 40) mode = MODE_DEQ;
        else if (r < 55) mode = MODE_PEEK;
        else if (r < 90) mode = MODE_SRCH;
        else if (r < 96) mode = allow_clr ? MODE_CLR : MODE_SRCH;
        else mode = 3'($urandom_range(MODE_UNUSED_MAX, MODE_SRCH + 1));
      end
      add_req(mode, pick_word());
    end
    wait_drained();
  endtask

  initial begin
    key_pool[0] = WORD_MIN;
    key_pool[1] = WORD_MAX;
    key_pool[2] = '0;
    key_pool[3] = -1;
    rst_n = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // reset capacity: empty refusals, wrap-free fill, first match, unused modes
    add_req(MODE_PEEK, '0);
    add_req(MODE_DEQ, '0);
    add_req(MODE_SRCH, '0);
    add_req(MODE_ENQ, WORD_MIN);
    add_req(MODE_ENQ, WORD_MAX);
    add_req(MODE_ENQ, '0);
    add_req(MODE_ENQ, -1);
    add_req(MODE_ENQ, WORD_MAX);
    add_req(MODE_SRCH, WORD_MAX);
    add_req(MODE_SRCH, -1);
    add_req(MODE_SRCH, 32'sd12345);
    add_req(MODE_PEEK, '0);
    add_req(MODE_DEQ, '0);
    add_req(MODE_DEQ, '0);
    add_req(MODE_SRCH, WORD_MAX);
    for (int m = MODE_SRCH + 1; m <= MODE_UNUSED_MAX; m++) add_req(3'(m), $urandom);
    add_req(MODE_CLR, $urandom);
    add_req(MODE_PEEK, '0);
    wait_drained();

    // single slot: full refusal and tail wrap
    set_capacity(9'd1);
    add_req(MODE_ENQ, 32'sd5);
    add_req(MODE_ENQ, 32'sd6);
    add_req(MODE_SRCH, 32'sd5);
    add_req(MODE_PEEK, '0);
    add_req(MODE_DEQ, '0);
    add_req(MODE_DEQ, '0);
    add_req(MODE_ENQ, 32'sd7);
    add_req(MODE_SRCH, 32'sd6);
    wait_drained();

    run_phase(9'd0, 48, 60, 45, 1'b1);
    run_phase(9'd2, 26, 80, 45, 1'b1);
    run_phase(9'd3, 0, 100, 45, 1'b1);
    run_phase(9'd5, 48, 120, 45, 1'b1);
    run_phase(9'd17, 26, 150, 50, 1'b1);
    run_phase(9'd256, 0, 320, 90, 1'b0);
    run_phase(9'd511, 48, 100, 55, 1'b0);
    run_phase(CAP_W'($urandom_range(255, 1)), 26, 120, 50, 1'b1);

    if (errors == 0) begin
      $display("circular_int_fifo_with_search_unit_tb OK");
    end else begin
      $display("circular_int_fifo_with_search_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("%0t: timeout", $time);
    $display("circular_int_fifo_with_search_unit_tb NOT OK");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/cisu_pkg.sv
rtl/core/cisu_ram.sv
rtl/core/cisu_ctrl.sv
rtl/core/circular_int_fifo_with_search_unit.sv
verif/circular_int_fifo_with_search_unit_tb.sv
